[rtl/core/mct_pkg.sv]
package mct_pkg;

    localparam int NUM_TIMERS           = 3;
    localparam int BLINK_HALF_PERIOD_MS = 1000;

    localparam int CNT_W  = 20;
    localparam int TICK_W = 10;
    localparam int PROG_W = 3;
    localparam int CODE_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Channel state codes, as they appear on the output.
    localparam logic [CODE_W-1:0] CH_OFF = 2'd0;
    localparam logic [CODE_W-1:0] CH_RUN = 2'd1;
    localparam logic [CODE_W-1:0] CH_FIN = 2'd2;

    // Status pixel color codes.
    localparam logic [CODE_W-1:0] COLOR_OFF   = 2'd0;
    localparam logic [CODE_W-1:0] COLOR_RED   = 2'd1;
    localparam logic [CODE_W-1:0] COLOR_GREEN = 2'd2;

    // Register map, one 32-bit word per register.
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_TICK         = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_START_HOLD   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STOP_HOLD    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_IGNORE_HOLD  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RUN_DURATION = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BLINK_SHOW   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SLEEP_WAIT   = 3'd6;

    localparam logic [TICK_W-1:0] RST_TICK         = 10'd100;
    localparam logic [CNT_W-1:0]  RST_START_HOLD   = 20'd100;
    localparam logic [CNT_W-1:0]  RST_STOP_HOLD    = 20'd2000;
    localparam logic [CNT_W-1:0]  RST_IGNORE_HOLD  = 20'd5000;
    localparam logic [CNT_W-1:0]  RST_RUN_DURATION = 20'd24000;
    localparam logic [CNT_W-1:0]  RST_BLINK_SHOW   = 20'd20000;
    localparam logic [CNT_W-1:0]  RST_SLEEP_WAIT   = 20'd5000;

    // Blink phase is bit 0 of elapsed / BLINK_HALF_PERIOD_MS, taken as a
    // multiply by a rounded-up reciprocal. With the shift at CNT_W plus the
    // bits of the divisor the quotient is exact for every counter value.
    localparam int BLINK_SHIFT = CNT_W + $clog2(BLINK_HALF_PERIOD_MS);
    localparam int RECIP_W     = CNT_W + 1;
    localparam int PROD_W      = CNT_W + RECIP_W;
    localparam logic [RECIP_W-1:0] BLINK_RECIP = RECIP_W'(
        ((64'd1 << BLINK_SHIFT) + 64'(BLINK_HALF_PERIOD_MS) - 64'd1)
        / 64'(BLINK_HALF_PERIOD_MS));

    // Stream layouts.
    localparam int S_DATA_W    = 8;
    localparam int COLOR_LSB   = 0;
    localparam int PROG_LSB    = CODE_W * NUM_TIMERS;
    localparam int STATE_LSB   = PROG_LSB + PROG_W * NUM_TIMERS;
    localparam int SLEEP_BIT   = STATE_LSB + CODE_W * NUM_TIMERS;
    localparam int M_DATA_W    = ((SLEEP_BIT + 1 + 7) / 8) * 8;

    typedef struct packed {
        logic [TICK_W-1:0] tick_ms;
        logic [CNT_W-1:0]  start_hold_ms;
        logic [CNT_W-1:0]  stop_hold_ms;
        logic [CNT_W-1:0]  ignore_hold_ms;
        logic [CNT_W-1:0]  run_duration_ms;
        logic [CNT_W-1:0]  blink_show_ms;
        logic [CNT_W-1:0]  sleep_wait_ms;
    } t_cfg;

    typedef struct packed {
        logic [CODE_W-1:0] color;
        logic [PROG_W-1:0] prog;
        logic [CODE_W-1:0] state;
        logic              sleep_block;
    } t_lane_out;

endpackage

[rtl/core/mct_lane.sv]
module mct_lane import mct_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  logic      i_pressed,
    input  t_cfg      i_cfg,
    output t_lane_out o_lane
);

    logic [CODE_W-1:0] r_state, n_state;
    logic [CNT_W-1:0]  r_elapsed, n_elapsed;
    logic [CNT_W-1:0]  r_hold, n_hold;

    // Snapshot of the updated channel, decoded into pixels one stage later.
    logic [CODE_W-1:0] r_s_state;
    logic [CNT_W-1:0]  r_s_elapsed;
    logic              r_s_pressed;
    logic              r_s_run;

    logic [CODE_W-1:0] st1;
    logic [CNT_W-1:0]  e1;
    logic [CNT_W:0]    hold_sum, elap_sum;
    logic [CNT_W-1:0]  hold_sat, elap_sat, tick_ext;

    logic [PROD_W-1:0]  prod;
    logic               blink_odd;
    logic [CNT_W+1:0]   e_x3, dur_x1, dur_x2;
    logic               show_on, sleep_wait_on;

    assign tick_ext = {{(CNT_W-TICK_W){1'b0}}, i_cfg.tick_ms};
    assign hold_sum = {1'b0, r_hold} + {1'b0, tick_ext};
    assign hold_sat = hold_sum[CNT_W] ? CNT_MAX : hold_sum[CNT_W-1:0];

    always_comb begin
        st1    = r_state;
        e1     = r_elapsed;
        n_hold = hold_sat;
        if (!i_pressed) begin
            n_hold = '0;
            if (r_hold > i_cfg.ignore_hold_ms) begin
                st1 = r_state;
            end else if (r_hold > i_cfg.stop_hold_ms) begin
                st1 = CH_OFF;
            end else if (r_hold > i_cfg.start_hold_ms && r_state != CH_RUN) begin
                st1 = CH_RUN;
                e1  = '0;
            end
        end
    end

    assign elap_sum = {1'b0, e1} + {1'b0, tick_ext};
    assign elap_sat = elap_sum[CNT_W] ? CNT_MAX : elap_sum[CNT_W-1:0];

    // A channel that runs out restarts its counter at zero and then counts
    // its first finished tick in the same update.
    always_comb begin
        n_state   = st1;
        n_elapsed = e1;
        case (st1)
            CH_RUN: begin
                if (elap_sat > i_cfg.run_duration_ms) begin
                    n_state   = CH_FIN;
                    n_elapsed = tick_ext;
                end else begin
                    n_elapsed = elap_sat;
                end
            end
            CH_FIN: begin
                n_elapsed = elap_sat;
            end
            default: begin
                n_elapsed = e1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= CH_OFF;
            r_elapsed <= '0;
            r_hold    <= '0;
        end else if (i_accept) begin
            r_state   <= n_state;
            r_elapsed <= n_elapsed;
            r_hold    <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s_state   <= n_state;
            r_s_elapsed <= n_elapsed;
            r_s_pressed <= i_pressed;
            r_s_run     <= (st1 == CH_RUN);
        end
    end

    assign prod      = {{RECIP_W{1'b0}}, r_s_elapsed} * {{CNT_W{1'b0}}, BLINK_RECIP};
    assign blink_odd = prod[BLINK_SHIFT];

    // e > floor(d/3) holds exactly when 3e > d, and likewise for 2d/3.
    assign e_x3   = {1'b0, r_s_elapsed, 1'b0} + {2'b00, r_s_elapsed};
    assign dur_x1 = {2'b00, i_cfg.run_duration_ms};
    assign dur_x2 = {1'b0, i_cfg.run_duration_ms, 1'b0};

    assign show_on       = (r_s_elapsed < i_cfg.blink_show_ms) && !blink_odd;
    assign sleep_wait_on = (r_s_elapsed < i_cfg.sleep_wait_ms);

    always_comb begin
        o_lane.color = COLOR_OFF;
        o_lane.prog  = '0;
        o_lane.state = r_s_state;
        case (r_s_state)
            CH_RUN: begin
                o_lane.color   = blink_odd ? COLOR_OFF : COLOR_RED;
                o_lane.prog[0] = (e_x3 > dur_x1);
                o_lane.prog[1] = (e_x3 > dur_x2);
            end
            CH_FIN: begin
                if (show_on) begin
                    o_lane.color = COLOR_GREEN;
                    o_lane.prog  = '1;
                end
            end
            default: begin
                o_lane.color = COLOR_OFF;
            end
        endcase
        o_lane.sleep_block = r_s_pressed || r_s_run
                             || ((r_s_state == CH_FIN) && sleep_wait_on);
    end

endmodule

[rtl/core/mct_merge.sv]
module mct_merge import mct_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_lane_out           i_lanes [NUM_TIMERS],
    input  logic                i_m_axis_tready,
    output logic                o_take,
    output logic                o_m_axis_tvalid,
    output logic [M_DATA_W-1:0] o_m_axis_tdata
);

    logic                r_valid;
    logic [M_DATA_W-1:0] r_data, n_data;

    assign o_take = !r_valid || i_m_axis_tready;

    always_comb begin
        n_data            = '0;
        n_data[SLEEP_BIT] = 1'b1;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            n_data[COLOR_LSB + CODE_W*i +: CODE_W] = i_lanes[i].color;
            n_data[PROG_LSB  + PROG_W*i +: PROG_W] = i_lanes[i].prog;
            n_data[STATE_LSB + CODE_W*i +: CODE_W] = i_lanes[i].state;
            if (i_lanes[i].sleep_block) begin
                n_data[SLEEP_BIT] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_data;

endmodule

[rtl/core/multi_countdown_timer_with_hold_buttons.sv]
// Channel   Direction  Handshake                        Payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  buttons_pressed, one tick
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  colors, progress, states, sleep
// apb       in         i_psel/i_penable/i_pwrite        seven timing registers
//
// One tick enters per clock cycle while the input is not stalled: the lane stage
// registers the updated channels at the transfer, and the pixel decode of that
// stage feeds the output register, which takes the result once it is free.
// Reset (synchronous, active low) turns every channel off and clears all counters.
// A stalled output holds its result; a new tick is still taken while the lane stage
// is free, and the input stalls only when both stages hold results.
module multi_countdown_timer_with_hold_buttons import mct_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // [2:0] buttons_pressed, [7:3] zero
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // [5:0] status_colors, [14:6] progress_mask, [20:15] timer_states,
    // [21] sleep_allowed, [23:22] zero
    output logic [M_DATA_W-1:0] o_m_axis_tdata,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [PADDR_W-1:0]  i_paddr,
    input  logic [31:0]         i_pwdata,
    output logic [31:0]         o_prdata,
    output logic                o_pready
);

    t_cfg             r_cfg;
    logic             r_s1_valid;
    logic             take;
    logic             accept;
    logic             cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;
    t_lane_out        lanes [NUM_TIMERS];

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;
    assign reg_idx  = i_paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_ms         <= RST_TICK;
            r_cfg.start_hold_ms   <= RST_START_HOLD;
            r_cfg.stop_hold_ms    <= RST_STOP_HOLD;
            r_cfg.ignore_hold_ms  <= RST_IGNORE_HOLD;
            r_cfg.run_duration_ms <= RST_RUN_DURATION;
            r_cfg.blink_show_ms   <= RST_BLINK_SHOW;
            r_cfg.sleep_wait_ms   <= RST_SLEEP_WAIT;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_TICK:         r_cfg.tick_ms         <= i_pwdata[TICK_W-1:0];
                REG_START_HOLD:   r_cfg.start_hold_ms   <= i_pwdata[CNT_W-1:0];
                REG_STOP_HOLD:    r_cfg.stop_hold_ms    <= i_pwdata[CNT_W-1:0];
                REG_IGNORE_HOLD:  r_cfg.ignore_hold_ms  <= i_pwdata[CNT_W-1:0];
                REG_RUN_DURATION: r_cfg.run_duration_ms <= i_pwdata[CNT_W-1:0];
                REG_BLINK_SHOW:   r_cfg.blink_show_ms   <= i_pwdata[CNT_W-1:0];
                REG_SLEEP_WAIT:   r_cfg.sleep_wait_ms   <= i_pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        case (reg_idx)
            REG_TICK:         o_prdata = {{(32-TICK_W){1'b0}}, r_cfg.tick_ms};
            REG_START_HOLD:   o_prdata = {{(32-CNT_W){1'b0}}, r_cfg.start_hold_ms};
            REG_STOP_HOLD:    o_prdata = {{(32-CNT_W){1'b0}}, r_cfg.stop_hold_ms};
            REG_IGNORE_HOLD:  o_prdata = {{(32-CNT_W){1'b0}}, r_cfg.ignore_hold_ms};
            REG_RUN_DURATION: o_prdata = {{(32-CNT_W){1'b0}}, r_cfg.run_duration_ms};
            REG_BLINK_SHOW:   o_prdata = {{(32-CNT_W){1'b0}}, r_cfg.blink_show_ms};
            REG_SLEEP_WAIT:   o_prdata = {{(32-CNT_W){1'b0}}, r_cfg.sleep_wait_ms};
            default:          o_prdata = '0;
        endcase
    end

    assign o_s_axis_tready = !r_s1_valid || take;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (take) begin
            r_s1_valid <= 1'b0;
        end
    end

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_lane
        logic pressed;
        if (g < 3) begin : g_btn
            assign pressed = i_s_axis_tdata[g];
        end else begin : g_nobtn
            assign pressed = 1'b0;
        end
        mct_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_accept  (accept),
            .i_pressed (pressed),
            .i_cfg     (r_cfg),
            .o_lane    (lanes[g])
        );
    end

    mct_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_s1_valid),
        .i_lanes         (lanes),
        .i_m_axis_tready (i_m_axis_tready),
        .o_take          (take),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // A full lane stage behind a stalled output must hold off the input.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while both stages are full and stalled");

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_chk
        // The unused state code never leaves a lane.
        assert property (@(posedge i_clk) disable iff (!i_rst_n)
            o_m_axis_tvalid |->
                (o_m_axis_tdata[STATE_LSB + CODE_W*g +: CODE_W] != 2'd3))
            else $error("unused channel state code on output");

        // Sleep is never allowed while a channel reports running.
        assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (o_m_axis_tvalid && o_m_axis_tdata[SLEEP_BIT]) |->
                (o_m_axis_tdata[STATE_LSB + CODE_W*g +: CODE_W] != CH_RUN))
            else $error("sleep allowed with a running channel");

        // The last progress pixel only lights together with a green status pixel.
        assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (o_m_axis_tvalid && o_m_axis_tdata[PROG_LSB + PROG_W*g + 2]) |->
                (o_m_axis_tdata[COLOR_LSB + CODE_W*g +: CODE_W] == COLOR_GREEN))
            else $error("third progress pixel lit without green status");
    end

endmodule
